// ----- rtl/core/box_open_close_animator_assert.svh -----
// Assertion macros for the box animator RTL.
`ifndef BOX_OPEN_CLOSE_ANIMATOR_ASSERT_SVH
`define BOX_OPEN_CLOSE_ANIMATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BOXOC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define BOXOC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/boxoc_pkg.sv -----
// Types and constants for the box open/close animator.
package boxoc_pkg;

    localparam int SCALE_W = 13;
    localparam int KIND_W  = 8;
    localparam int CUR_W   = 2;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = 13'd4096;
    localparam logic [SCALE_W-1:0] SCALE_FLOOR = 13'd64;
    localparam logic [SCALE_W-1:0] SHUT_LIMIT  = 13'd5;
    localparam logic [SCALE_W:0]   STEP_OUT    = 14'd768;
    localparam logic [SCALE_W:0]   STEP_IN     = 14'd200;
    localparam logic [KIND_W-1:0]  KIND_OPEN   = 8'hF0;
    // ceil(2^17 / 3): exact divide by three for values below 2^16
    localparam logic [15:0]        DIV3_RECIP  = 16'hAAAB;

    localparam logic [CUR_W-1:0] CUR_NONE = 2'd0;
    localparam logic [CUR_W-1:0] CUR_HIDE = 2'd1;
    localparam logic [CUR_W-1:0] CUR_SHOW = 2'd2;

    localparam logic [3:0] MOT_HOLD     = 4'd0;
    localparam logic [3:0] MOT_GROW     = 4'd1;
    localparam logic [3:0] MOT_UNROLL   = 4'd2;
    localparam logic [3:0] MOT_ROLL     = 4'd3;
    localparam logic [3:0] MOT_OPEN     = 4'd4;
    localparam logic [3:0] MOT_SHUT     = 4'd5;
    localparam logic [3:0] MOT_SHRINK   = 4'd6;
    localparam logic [3:0] MOT_COLLAPSE = 4'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind_byte;
        logic [SCALE_W-1:0] width_scale;
        logic [SCALE_W-1:0] height_scale;
        logic [SCALE_W-1:0] overall_scale;
    } box_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]  next_kind_byte;
        logic [SCALE_W-1:0] next_width_scale;
        logic [SCALE_W-1:0] next_height_scale;
        logic [SCALE_W-1:0] next_overall_scale;
        logic               still_running;
        logic [CUR_W-1:0]   cursor_command;
    } box_out_t;

endpackage

// ----- rtl/core/boxoc_step.sv -----
// Combinational one-frame update of a box record.
module boxoc_step (
    input  boxoc_pkg::box_in_t  box_in,
    output boxoc_pkg::box_out_t box_out
);
    import boxoc_pkg::*;

    logic [SCALE_W-1:0] w, h, s;
    logic [KIND_W-1:0]  kind;
    logic [SCALE_W:0]   w_grow, h_grow, h_up, h_roll, w_coll, h_coll;
    logic [28:0]        w_prod, h_prod;
    logic [SCALE_W-1:0] w_shr, h_shr;

    // Scales above unity saturate before use.
    assign w    = (box_in.width_scale  > SCALE_ONE) ? SCALE_ONE : box_in.width_scale;
    assign h    = (box_in.height_scale > SCALE_ONE) ? SCALE_ONE : box_in.height_scale;
    assign s    = (box_in.overall_scale > SCALE_ONE) ? SCALE_ONE : box_in.overall_scale;
    assign kind = box_in.kind_byte;

    assign w_grow = {1'b0, w} + {2'b00, w[SCALE_W-1:1]};
    assign h_grow = {1'b0, h} + {2'b00, h[SCALE_W-1:1]};
    assign h_up   = {1'b0, h} + STEP_OUT;
    assign h_roll = {1'b0, h} - STEP_IN;
    assign w_coll = {1'b0, w} - STEP_IN;
    assign h_coll = {1'b0, h} - STEP_IN;

    // Divide by three through a reciprocal multiply.
    assign w_prod = w * DIV3_RECIP;
    assign h_prod = h * DIV3_RECIP;
    assign w_shr  = w - {1'b0, w_prod[28:17]};
    assign h_shr  = h - {1'b0, h_prod[28:17]};

    always_comb begin
        box_out.next_kind_byte     = kind;
        box_out.next_width_scale   = w;
        box_out.next_height_scale  = h;
        box_out.next_overall_scale = s;
        box_out.still_running      = 1'b1;
        box_out.cursor_command     = CUR_NONE;
        unique case (kind[3:0])
            MOT_GROW: begin
                box_out.cursor_command   = CUR_HIDE;
                box_out.next_width_scale = w_grow[SCALE_W-1:0];
                if (w_grow >= {1'b0, SCALE_ONE}) begin
                    box_out.next_width_scale  = SCALE_ONE;
                    box_out.next_height_scale = h_grow[SCALE_W-1:0];
                    if (h_grow >= {1'b0, SCALE_ONE}) begin
                        box_out.cursor_command     = CUR_SHOW;
                        box_out.next_height_scale  = SCALE_ONE;
                        box_out.next_overall_scale = SCALE_ONE;
                        box_out.next_kind_byte     = {kind[7:4], 4'h0};
                    end
                end
            end
            MOT_UNROLL: begin
                box_out.next_width_scale  = SCALE_ONE;
                box_out.next_height_scale = h_up[SCALE_W-1:0];
                if (h_up >= {1'b0, SCALE_ONE}) begin
                    box_out.next_height_scale  = SCALE_ONE;
                    box_out.next_overall_scale = SCALE_ONE;
                    box_out.next_kind_byte     = KIND_OPEN;
                end
            end
            MOT_ROLL: begin
                box_out.next_width_scale  = SCALE_ONE;
                box_out.next_height_scale = h_roll[SCALE_W-1:0];
                if (h_roll[SCALE_W]) begin
                    box_out.next_width_scale   = '0;
                    box_out.next_height_scale  = '0;
                    box_out.next_overall_scale = '0;
                    box_out.next_kind_byte     = '0;
                    box_out.still_running      = 1'b0;
                end
            end
            MOT_OPEN: begin
                box_out.next_width_scale   = SCALE_ONE;
                box_out.next_height_scale  = SCALE_ONE;
                box_out.next_overall_scale = SCALE_ONE;
                box_out.next_kind_byte     = {kind[7:4], 4'h0};
                box_out.cursor_command     = CUR_SHOW;
            end
            MOT_SHUT: begin
                box_out.next_width_scale   = '0;
                box_out.next_height_scale  = '0;
                box_out.next_overall_scale = '0;
                box_out.next_kind_byte     = '0;
                box_out.cursor_command     = CUR_HIDE;
                box_out.still_running      = 1'b0;
            end
            MOT_SHRINK: begin
                box_out.cursor_command    = CUR_HIDE;
                box_out.next_height_scale = h_shr;
                if (h_shr <= SCALE_FLOOR) begin
                    box_out.next_width_scale  = w_shr;
                    box_out.next_height_scale = SCALE_FLOOR;
                    if (w_shr < SHUT_LIMIT) begin
                        box_out.next_width_scale   = '0;
                        box_out.next_height_scale  = '0;
                        box_out.next_overall_scale = SCALE_ONE;
                        box_out.next_kind_byte     = '0;
                        box_out.still_running      = 1'b0;
                    end
                end
            end
            MOT_COLLAPSE: begin
                box_out.next_width_scale  = w_coll[SCALE_W-1:0];
                box_out.next_height_scale = h_coll[SCALE_W-1:0];
                if (w_coll[SCALE_W]) begin
                    box_out.next_width_scale   = '0;
                    box_out.next_height_scale  = '0;
                    box_out.next_overall_scale = SCALE_ONE;
                    box_out.next_kind_byte     = '0;
                end else if (h_coll[SCALE_W]) begin
                    box_out.next_height_scale = '0;
                end
            end
            default: begin
                // Hold and the unused selectors leave the record alone.
                box_out.next_kind_byte = kind;
            end
        endcase
    end

endmodule

// ----- rtl/core/box_open_close_animator.sv -----
// Box animator top level: input register, frame update and result register.
// Path: an accepted item is captured in the input register, passes through the frame
// update and is presented on the result ports once captured in the result register.
// Throughput: one item per cycle; the two registers form a pipeline that stalls only
// when the result side withholds m_ready.
// Reset (aresetn low, synchronous) empties both stages; payload registers are not reset.
`include "box_open_close_animator_assert.svh"

module box_open_close_animator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [boxoc_pkg::KIND_W-1:0]        s_kind_byte,
    input  logic [boxoc_pkg::SCALE_W-1:0]       s_width_scale,
    input  logic [boxoc_pkg::SCALE_W-1:0]       s_height_scale,
    input  logic [boxoc_pkg::SCALE_W-1:0]       s_overall_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [boxoc_pkg::KIND_W-1:0]        m_next_kind_byte,
    output logic [boxoc_pkg::SCALE_W-1:0]       m_next_width_scale,
    output logic [boxoc_pkg::SCALE_W-1:0]       m_next_height_scale,
    output logic [boxoc_pkg::SCALE_W-1:0]       m_next_overall_scale,
    output logic                                m_still_running,
    output logic [boxoc_pkg::CUR_W-1:0]         m_cursor_command
);
    import boxoc_pkg::*;

    logic     in_valid_reg, in_valid_next;
    logic     out_valid_reg, out_valid_next;
    box_in_t  in_reg;
    box_out_t out_reg;
    box_out_t step_out;
    logic     out_free, in_free;

    // The result stage moves on when empty or when its item is taken.
    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    boxoc_step u_step (
        .box_in  (in_reg),
        .box_out (step_out)
    );

    always_comb begin
        in_valid_next  = in_free  ? s_valid      : in_valid_reg;
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_reg.kind_byte     <= s_kind_byte;
            in_reg.width_scale   <= s_width_scale;
            in_reg.height_scale  <= s_height_scale;
            in_reg.overall_scale <= s_overall_scale;
        end
        if (out_free && in_valid_reg) begin
            out_reg <= step_out;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_next_kind_byte     = out_reg.next_kind_byte;
    assign m_next_width_scale   = out_reg.next_width_scale;
    assign m_next_height_scale  = out_reg.next_height_scale;
    assign m_next_overall_scale = out_reg.next_overall_scale;
    assign m_still_running      = out_reg.still_running;
    assign m_cursor_command     = out_reg.cursor_command;

    // An accepted item always lands in the input stage.
    `BOXOC_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, in_valid_reg)
    // A full input stage with a free result stage hands its item on.
    `BOXOC_ASSERT_NEXT(a_stage_moves, aclk, aresetn, in_valid_reg && out_free, out_valid_reg)
    // A box that is gone carries a zero kind byte.
    `BOXOC_ASSERT_NOW(a_gone_kind, aclk, aresetn, m_valid && !m_still_running,
                      m_next_kind_byte == '0)
    // Showing the cursor only happens once the box is fully open.
    `BOXOC_ASSERT_NOW(a_show_open, aclk, aresetn, m_valid && (m_cursor_command == CUR_SHOW),
                      (m_next_width_scale == SCALE_ONE) && (m_next_height_scale == SCALE_ONE)
                      && (m_next_kind_byte[3:0] == 4'h0))

endmodule
